[hdl/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/gps_pkg.sv]
// Package of the GOOSE publish scheduler: widths, register codes, reset values
package gps_pkg;

	localparam int DIG_CH = 16;
	localparam int ANA_CH = 4;

	localparam int DIG_W     = 16;
	localparam int DIG_CNT_W = 5;
	localparam int ANA_CNT_W = 3;
	localparam int ANA_W     = 32;
	localparam int DB_W      = 31;
	localparam int TIME_W    = 64;
	localparam int CNT_W     = 32;
	localparam int MIN_W     = 32;
	localparam int TTL_MS_W  = 16;
	localparam int NSPM_W    = 20;
	localparam int TTL_NS_W  = TTL_MS_W + NSPM_W;
	localparam int RETX_W    = TTL_NS_W + 1;
	localparam int CHG_W     = 5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TTL_MS       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIGITAL_CNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ANALOG_CNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_A0  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_A1  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_A2  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_A3  = 3'd7;

	localparam logic [NSPM_W-1:0]   NS_PER_MS      = 20'd1000000;
	localparam logic [MIN_W-1:0]    MIN_INTERVAL_RST = 32'd2000000;
	localparam logic [TTL_MS_W-1:0] TTL_MS_RST     = 16'd1000;
	localparam logic [TTL_NS_W-1:0] TTL_NS_RST     = 36'd1000000000;

	typedef logic [ANA_CH-1:0][ANA_W-1:0] analog_vec_t;
	typedef logic [ANA_CH-1:0][DB_W-1:0]  deadband_vec_t;

endpackage

[hdl/gps_in_if.sv]
// Tick channel: time, digital bits and analog values
interface gps_in_if;
	import gps_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [TIME_W-1:0]        now_ns;
	logic [DIG_W-1:0]         digital_bits;
	logic signed [ANA_W-1:0]  analog_v0;
	logic signed [ANA_W-1:0]  analog_v1;
	logic signed [ANA_W-1:0]  analog_v2;
	logic signed [ANA_W-1:0]  analog_v3;

	modport source (output valid, now_ns, digital_bits, analog_v0, analog_v1, analog_v2,
		analog_v3, input ready);
	modport sink (input valid, now_ns, digital_bits, analog_v0, analog_v1, analog_v2,
		analog_v3, output ready);
endinterface

[hdl/gps_out_if.sv]
// Result channel: send flag, state and sequence numbers, frame timestamp
interface gps_out_if;
	import gps_pkg::*;

	logic              valid;
	logic              ready;
	logic              send_now;
	logic [CNT_W-1:0]  state_number;
	logic [CNT_W-1:0]  sequence_number;
	logic [TIME_W-1:0] frame_time_ns;

	modport source (output valid, send_now, state_number, sequence_number, frame_time_ns,
		input ready);
	modport sink (input valid, send_now, state_number, sequence_number, frame_time_ns,
		output ready);
endinterface

[hdl/goose_publish_scheduler.sv]
// Top level of the GOOSE publish scheduler
// Usage:
//  - tick (sink): one transaction per time tick carrying now_ns, the digital
//    bits and four signed Q16.16 analog values.
//  - frame (source): exactly one transaction per tick with send_now, the
//    state number, the sequence number of the frame and its timestamp.
//  - cfg_we/cfg_index/cfg_wdata: register writes, only while no tick is in
//    flight; a new ttl_ms is scaled to ns in the cycle after the write.
// Timing:
//  - a tick is captured in an input register; the next edge that finds the
//    result register free or being emptied computes it and loads the result.
//  - from tick acceptance to frame valid a tick passes the input register
//    and then the result register; a held frame delays the second.
//  - throughput: one tick per cycle while frames are taken; the update of the
//    sequence/state/interval registers from their own values is the loop that sets this rate.
// Reset: configuration returns to its defaults, counters and history clear,
//   the interval returns to the minimum, both stages empty.
// Stall: a held frame keeps its payload; one further tick waits in the
//   input register, then tick.ready drops until the frame is taken.
module goose_publish_scheduler import gps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	gps_in_if.sink                tick,
	gps_out_if.source             frame
);

	// configuration registers
	logic [MIN_W-1:0]     min_interval_q;
	logic [TTL_MS_W-1:0]  ttl_ms_q;
	logic [TTL_NS_W-1:0]  ttl_ns_q;
	logic [DIG_CNT_W-1:0] digital_count_q;
	logic [ANA_CNT_W-1:0] analog_count_q;
	deadband_vec_t        deadband_q;

	// scheduler state
	logic [TIME_W-1:0] last_send_q;
	logic [RETX_W-1:0] retx_q;
	logic [CNT_W-1:0]  seq_q;
	logic [CNT_W-1:0]  state_q;
	logic [DIG_W-1:0]  prev_digital_q;
	analog_vec_t       prev_analog_q;

	// input stage
	logic              valid_s1;
	logic [TIME_W-1:0] now_s1;
	logic [DIG_W-1:0]  digital_s1;
	analog_vec_t       analog_s1;

	// result register
	logic              out_valid_q;
	logic              send_q;
	logic [CNT_W-1:0]  state_out_q;
	logic [CNT_W-1:0]  seq_out_q;
	logic [TIME_W-1:0] time_out_q;

	logic              advance;
	logic              enabled;
	logic [CHG_W-1:0]  changes;
	logic [CNT_W-1:0]  seq_base;
	logic [CNT_W-1:0]  state_nxt;
	logic [RETX_W-1:0] interval;
	logic [TIME_W-1:0] elapsed;
	logic              send;
	logic [RETX_W-1:0] retx_nxt;

	// --- configuration write port ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q  <= MIN_INTERVAL_RST;
			ttl_ms_q        <= TTL_MS_RST;
			digital_count_q <= '0;
			analog_count_q  <= '0;
			deadband_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_INTERVAL: min_interval_q  <= cfg_wdata[MIN_W-1:0];
				CFG_TTL_MS:       ttl_ms_q        <= cfg_wdata[TTL_MS_W-1:0];
				CFG_DIGITAL_CNT:  digital_count_q <= cfg_wdata[DIG_CNT_W-1:0];
				CFG_ANALOG_CNT:   analog_count_q  <= cfg_wdata[ANA_CNT_W-1:0];
				CFG_DEADBAND_A0:  deadband_q[0]   <= cfg_wdata[DB_W-1:0];
				CFG_DEADBAND_A1:  deadband_q[1]   <= cfg_wdata[DB_W-1:0];
				CFG_DEADBAND_A2:  deadband_q[2]   <= cfg_wdata[DB_W-1:0];
				CFG_DEADBAND_A3:  deadband_q[3]   <= cfg_wdata[DB_W-1:0];
				default: ;
			endcase
		end
	end

	// ttl in ns: 16x20 product, registered so it stays off the tick path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_ns_q <= TTL_NS_RST;
		end else begin
			ttl_ns_q <= TTL_NS_W'(ttl_ms_q * NS_PER_MS);
		end
	end

	// --- handshake: stage 1 moves on when the result register frees up ---
	assign advance     = valid_s1 && (!out_valid_q || frame.ready);
	assign tick.ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			now_s1       <= tick.now_ns;
			digital_s1   <= tick.digital_bits;
			analog_s1[0] <= tick.analog_v0;
			analog_s1[1] <= tick.analog_v1;
			analog_s1[2] <= tick.analog_v2;
			analog_s1[3] <= tick.analog_v3;
		end
	end

	// --- change detection ---
	gps_change u_change (
		.digital_bits  (digital_s1),
		.prev_digital  (prev_digital_q),
		.digital_count (digital_count_q),
		.analog        (analog_s1),
		.prev_analog   (prev_analog_q),
		.analog_count  (analog_count_q),
		.deadband      (deadband_q),
		.changes       (changes)
	);

	// --- retransmission timing ---
	// any change restarts the sequence; sequence zero restores the minimum interval
	assign enabled   = (digital_count_q != '0) || (analog_count_q != '0);
	assign seq_base  = (changes != '0) ? '0 : seq_q;
	assign state_nxt = state_q + CNT_W'(changes);
	assign interval  = (seq_base == '0) ? RETX_W'(min_interval_q) : retx_q;
	assign elapsed   = now_s1 - last_send_q;
	assign send      = enabled && (elapsed >= TIME_W'(interval));

	// on a send, double below the ttl, otherwise clamp to it; without a send it holds
	always_comb begin
		if (!send) begin
			retx_nxt = interval;
		end else if (interval < RETX_W'(ttl_ns_q)) begin
			retx_nxt = {interval[RETX_W-2:0], 1'b0};
		end else begin
			retx_nxt = RETX_W'(ttl_ns_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_send_q    <= '0;
			retx_q         <= RETX_W'(MIN_INTERVAL_RST);
			seq_q          <= '0;
			state_q        <= '0;
			prev_digital_q <= '0;
			prev_analog_q  <= '0;
		end else if (advance) begin
			state_q        <= state_nxt;
			prev_digital_q <= digital_s1;
			prev_analog_q  <= analog_s1;
			seq_q          <= send ? seq_base + CNT_W'(1) : seq_base;
			if (enabled) begin
				retx_q <= retx_nxt;
			end
			if (send) begin
				last_send_q <= now_s1;
			end
		end
	end

	// --- result register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			send_q      <= send;
			state_out_q <= state_nxt;
			seq_out_q   <= seq_base;
			time_out_q  <= send ? now_s1 : last_send_q;
		end
	end

	assign frame.valid           = out_valid_q;
	assign frame.send_now        = send_q;
	assign frame.state_number    = state_out_q;
	assign frame.sequence_number = seq_out_q;
	assign frame.frame_time_ns   = time_out_q;

endmodule

[hdl/gps_change.sv]
// Change detector: counts changed digital channels and analog deadband hits
module gps_change import gps_pkg::*; (
	input  logic [DIG_W-1:0]     digital_bits,
	input  logic [DIG_W-1:0]     prev_digital,
	input  logic [DIG_CNT_W-1:0] digital_count,
	input  analog_vec_t          analog,
	input  analog_vec_t          prev_analog,
	input  logic [ANA_CNT_W-1:0] analog_count,
	input  deadband_vec_t        deadband,
	output logic [CHG_W-1:0]     changes
);

	logic [DIG_CNT_W-1:0] nd;
	logic [ANA_CNT_W-1:0] na;
	logic [DIG_W-1:0]     diff_bits;
	logic [CHG_W-1:0]     pop_lo;
	logic [CHG_W-1:0]     pop_hi;
	logic [CHG_W-1:0]     ana_hits;

	// clamp enable counts to the channels present
	assign nd = (digital_count > DIG_CNT_W'(DIG_CH)) ? DIG_CNT_W'(DIG_CH) : digital_count;
	assign na = (analog_count > ANA_CNT_W'(ANA_CH)) ? ANA_CNT_W'(ANA_CH) : analog_count;

	always_comb begin
		for (int i = 0; i < DIG_W; i++) begin
			diff_bits[i] = (digital_bits[i] ^ prev_digital[i]) & (DIG_CNT_W'(i) < nd);
		end
	end

	// two independent halves keep the adder chain short
	always_comb begin
		pop_lo = '0;
		pop_hi = '0;
		for (int i = 0; i < DIG_W / 2; i++) begin
			pop_lo = pop_lo + CHG_W'(diff_bits[i]);
			pop_hi = pop_hi + CHG_W'(diff_bits[i + DIG_W / 2]);
		end
	end

	always_comb begin
		logic signed [ANA_W:0] d;
		logic [ANA_W:0]        mag;
		ana_hits = '0;
		for (int i = 0; i < ANA_CH; i++) begin
			d   = $signed({analog[i][ANA_W-1], analog[i]})
				- $signed({prev_analog[i][ANA_W-1], prev_analog[i]});
			mag = d[ANA_W] ? (ANA_W+1)'(-d) : (ANA_W+1)'(d);
			if ((ANA_CNT_W'(i) < na) && (mag >= (ANA_W+1)'(deadband[i]))) begin
				ana_hits = ana_hits + CHG_W'(1);
			end
		end
	end

	assign changes = pop_lo + pop_hi + ana_hits;

endmodule

[hdl/gps_checker.sv]
// Port-level checker of the GOOSE publish scheduler, bound to the top level
`include "assert_macros.svh"

module gps_checker import gps_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              frame_valid,
	input logic              frame_ready,
	input logic              send_now,
	input logic [CNT_W-1:0]  state_number,
	input logic [CNT_W-1:0]  sequence_number,
	input logic [TIME_W-1:0] frame_time_ns
);

	logic              frame_take;
	logic [TIME_W-1:0] time_q;
	logic [CNT_W-1:0]  state_q;
	logic [CNT_W-1:0]  seq_exp_q;

	assign frame_take = frame_valid && frame_ready;

	// shadow of the last delivered frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q    <= '0;
			state_q   <= '0;
			seq_exp_q <= '0;
		end else if (frame_take) begin
			time_q    <= frame_time_ns;
			state_q   <= state_number;
			seq_exp_q <= sequence_number + CNT_W'(send_now);
		end
	end

	`GPS_ASSERT_NEXT(a_frame_hold, clk, arst_n, frame_valid && !frame_ready,
		frame_valid && $stable(send_now) && $stable(state_number) && $stable(sequence_number) && $stable(frame_time_ns),
		"stalled frame changed")

	`GPS_ASSERT_NOW(a_time_kept, clk, arst_n, frame_valid && !send_now,
		frame_time_ns == time_q, "timestamp moved without a send")

	`GPS_ASSERT_NOW(a_seq_step, clk, arst_n, frame_valid && (state_number == state_q),
		sequence_number == seq_exp_q, "sequence number skipped without a state change")

	`GPS_ASSERT_NOW(a_seq_restart, clk, arst_n, frame_valid && (state_number != state_q),
		sequence_number == '0, "state change did not restart the sequence")

endmodule

bind goose_publish_scheduler gps_checker u_gps_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.frame_valid     (frame.valid),
	.frame_ready     (frame.ready),
	.send_now        (frame.send_now),
	.state_number    (frame.state_number),
	.sequence_number (frame.sequence_number),
	.frame_time_ns   (frame.frame_time_ns)
);

[sim/goose_publish_scheduler_test.sv]
// Self-checking testbench of the GOOSE publish scheduler: random ticks against a predictor
module goose_publish_scheduler_test import gps_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// One tick as offered on the input channel
	typedef struct {
		logic [TIME_W-1:0] now;
		logic [DIG_W-1:0]  bits;
		analog_vec_t       av;
	} tick_t;

	// One frame decision as expected on the output channel
	typedef struct {
		logic              send;
		logic [CNT_W-1:0]  state;
		logic [CNT_W-1:0]  seq;
		logic [TIME_W-1:0] stamp;
	} frame_t;

	// Flow-control regimes, stepped through as ticks are accepted
	typedef enum int {FLOW_FREE, FLOW_TX_SPARSE, FLOW_RX_STALL, FLOW_BOTH} flow_mode_t;

	localparam int FLOW_SPAN    = 37;   // ticks per flow regime
	localparam int HOLD_CYCLES  = 300;  // length of a receiver hold-off
	localparam int HOLD_EVERY   = 250;  // hold-off spacing, in accepted ticks
	localparam int HOLD_OFFSET  = 100;
	localparam int QUIET_CYCLES = 4;    // settle time once the pipe has drained

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	gps_in_if  tick_ch ();
	gps_out_if frame_ch ();

	goose_publish_scheduler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.tick      (tick_ch.sink),
		.frame     (frame_ch.source)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------
	// Mirror of the registers, as last written
	// ---------------------------------------------------------------
	logic [MIN_W-1:0]     reg_min_iv  = MIN_INTERVAL_RST;
	logic [TTL_MS_W-1:0]  reg_ttl_ms  = TTL_MS_RST;
	logic [DIG_CNT_W-1:0] reg_dig_cnt = '0;
	logic [ANA_CNT_W-1:0] reg_ana_cnt = '0;
	deadband_vec_t        reg_db      = '0;

	// ---------------------------------------------------------------
	// Publisher state as the predictor sees it; reset happens once only,
	// so the declaration values stand in for the reset state.
	// ---------------------------------------------------------------
	logic [TIME_W-1:0] pub_last_send = '0;
	logic [TIME_W-1:0] pub_interval  = TIME_W'(MIN_INTERVAL_RST);
	logic [CNT_W-1:0]  pub_seq       = '0;
	logic [CNT_W-1:0]  pub_state     = '0;
	logic [DIG_W-1:0]  pub_prev_bits = '0;
	analog_vec_t       pub_prev_av   = '0;

	tick_t  pending_ticks[$];  // filled by the stimulus, drained by the driver
	frame_t frames_due[$];     // predicted frames, oldest first
	tick_t  offered;           // tick currently on the input channel

	int n_queued    = 0;
	int n_accepted  = 0;
	int n_checked   = 0;
	int n_sends     = 0;
	int n_settings  = 0;
	int n_holds     = 0;
	int mismatches  = 0;
	int hold_left   = 0;
	int hold_mark   = -1;

	// Works out the frame decision for one accepted tick and moves the
	// predicted publisher state on by one tick.
	function automatic frame_t publish_step(tick_t t);
		frame_t            f;
		int                nd;
		int                na;
		int unsigned       mask;
		logic [CNT_W-1:0]  changes;
		longint            diff;
		logic [TIME_W-1:0] ttl_ns;
		logic [TIME_W-1:0] elapsed;

		// counts beyond the channels present are clipped
		nd = int'(reg_dig_cnt);
		if (nd > DIG_CH) nd = DIG_CH;
		if (nd > DIG_W) nd = DIG_W;
		na = int'(reg_ana_cnt);
		if (na > ANA_CH) na = ANA_CH;

		mask = (nd >= DIG_W) ? 32'h0000_FFFF : ((32'd1 << nd) - 32'd1);
		changes = CNT_W'($countones((t.bits ^ pub_prev_bits) & DIG_W'(mask)));

		// analog change is the exact 33-bit difference against the deadband
		for (int i = 0; i < na; i++) begin
			diff = longint'($signed(t.av[i])) - longint'($signed(pub_prev_av[i]));
			if (diff < 0) diff = -diff;
			if (diff >= longint'({1'b0, reg_db[i]})) changes++;
		end

		if (changes != 0) begin
			pub_seq   = '0;
			pub_state = pub_state + changes;
		end

		// history is kept for every channel, enabled or not
		pub_prev_bits = t.bits;
		pub_prev_av   = t.av;

		f.send = 1'b0;
		f.seq  = pub_seq;
		if (nd > 0 || na > 0) begin
			ttl_ns = TIME_W'(reg_ttl_ms) * 64'd1000000;
			if (pub_seq == 0) pub_interval = TIME_W'(reg_min_iv);
			elapsed = t.now - pub_last_send;  // wraps when time runs backwards
			if (elapsed >= pub_interval) begin
				f.send        = 1'b1;
				f.seq         = pub_seq;
				pub_last_send = t.now;
				pub_seq       = pub_seq + 1'b1;
				if (pub_interval < ttl_ns) pub_interval = pub_interval << 1;
				else pub_interval = ttl_ns;
			end
		end
		f.state = pub_state;
		f.stamp = pub_last_send;
		return f;
	endfunction

	// Random idle decision for either side under the current flow regime
	function automatic bit idle_roll(bit rx_side);
		flow_mode_t mode;
		int         pct;

		mode = flow_mode_t'((n_accepted / FLOW_SPAN) % 4);
		case (mode)
			FLOW_FREE:      pct = 0;
			FLOW_TX_SPARSE: pct = rx_side ? 0 : 76;
			FLOW_RX_STALL:  pct = rx_side ? 76 : 0;
			default:        pct = 29;
		endcase
		return $urandom_range(99) < pct;
	endfunction

	// ---------------------------------------------------------------
	// Driver: offers pending ticks, holds an offer until its transaction
	// completes, and predicts each accepted tick at the accepting edge.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		frame_t fr;
		bit     stuck;

		if (!arst_n) begin
			tick_ch.valid <= 1'b0;
		end else begin
			stuck = tick_ch.valid && !tick_ch.ready;
			if (tick_ch.valid && tick_ch.ready) begin
				fr = publish_step(offered);
				frames_due = {frames_due, fr};
				if (fr.send) n_sends++;
				n_accepted <= n_accepted + 1;
			end
			if (!stuck) begin
				if (pending_ticks.size() != 0 && !idle_roll(1'b0)) begin
					offered = pending_ticks.pop_front();
					tick_ch.valid        <= 1'b1;
					tick_ch.now_ns       <= offered.now;
					tick_ch.digital_bits <= offered.bits;
					tick_ch.analog_v0    <= offered.av[0];
					tick_ch.analog_v1    <= offered.av[1];
					tick_ch.analog_v2    <= offered.av[2];
					tick_ch.analog_v3    <= offered.av[3];
				end else begin
					tick_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver hold-off: at fixed points in the run the frame side stops
	// taking transactions for a long stretch, so the tick side backs up.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (n_accepted % HOLD_EVERY == HOLD_OFFSET && n_accepted != hold_mark) begin
			hold_left <= HOLD_CYCLES;
			hold_mark <= n_accepted;
			n_holds++;
		end
	end

	// ---------------------------------------------------------------
	// Monitor: every frame transaction is checked against the oldest
	// prediction, field by field.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		frame_t want;

		if (!arst_n) begin
			frame_ch.ready <= 1'b0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				n_checked <= n_checked + 1;
				if (frames_due.size() == 0) begin
					$error("frame transaction with no tick outstanding");
					mismatches++;
				end else begin
					want = frames_due.pop_front();
					if (frame_ch.send_now !== want.send) begin
						$error("send_now: expected %0d, actual %0d", want.send,
							frame_ch.send_now);
						mismatches++;
					end
					if (frame_ch.state_number !== want.state) begin
						$error("state_number: expected %0d, actual %0d", want.state,
							frame_ch.state_number);
						mismatches++;
					end
					if (frame_ch.sequence_number !== want.seq) begin
						$error("sequence_number: expected %0d, actual %0d", want.seq,
							frame_ch.sequence_number);
						mismatches++;
					end
					if (frame_ch.frame_time_ns !== want.stamp) begin
						$error("frame_time_ns: expected %0h, actual %0h", want.stamp,
							frame_ch.frame_time_ns);
						mismatches++;
					end
				end
			end
			frame_ch.ready <= (hold_left == 0) && !idle_roll(1'b1);
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	logic [TIME_W-1:0] gen_now  = '0;  // last values queued, for the generator
	logic [DIG_W-1:0]  gen_bits = '0;
	analog_vec_t       gen_av   = '0;

	task automatic push_tick(logic [TIME_W-1:0] now, logic [DIG_W-1:0] bits,
			logic [ANA_W-1:0] a0, logic [ANA_W-1:0] a1, logic [ANA_W-1:0] a2,
			logic [ANA_W-1:0] a3);
		tick_t t;

		t.now   = now;
		t.bits  = bits;
		t.av[0] = a0;
		t.av[1] = a1;
		t.av[2] = a2;
		t.av[3] = a3;
		pending_ticks = {pending_ticks, t};
		n_queued++;
		gen_now  = now;
		gen_bits = bits;
		gen_av   = t.av;
	endtask

	// Waits until every queued tick has produced its frame, then lets the
	// pipe settle before the registers are touched.
	task automatic wait_quiet();
		while (!(n_accepted == n_queued && n_checked == n_queued))
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// Writes all eight registers and updates the mirror; only called idle
	task automatic program_regs(logic [MIN_W-1:0] min_iv, logic [TTL_MS_W-1:0] ttl,
			logic [DIG_CNT_W-1:0] dcnt, logic [ANA_CNT_W-1:0] acnt, deadband_vec_t db);
		logic [CFG_IDX_W-1:0]  idx [8];
		logic [CFG_DATA_W-1:0] val [8];

		idx[0] = CFG_MIN_INTERVAL; val[0] = min_iv;
		idx[1] = CFG_TTL_MS;       val[1] = CFG_DATA_W'(ttl);
		idx[2] = CFG_DIGITAL_CNT;  val[2] = CFG_DATA_W'(dcnt);
		idx[3] = CFG_ANALOG_CNT;   val[3] = CFG_DATA_W'(acnt);
		idx[4] = CFG_DEADBAND_A0;  val[4] = CFG_DATA_W'(db[0]);
		idx[5] = CFG_DEADBAND_A1;  val[5] = CFG_DATA_W'(db[1]);
		idx[6] = CFG_DEADBAND_A2;  val[6] = CFG_DATA_W'(db[2]);
		idx[7] = CFG_DEADBAND_A3;  val[7] = CFG_DATA_W'(db[3]);
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= val[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		// ttl is scaled to ns in the cycle after its write
		repeat (2) @(posedge clk);
		reg_min_iv  = min_iv;
		reg_ttl_ms  = ttl;
		reg_dig_cnt = dcnt;
		reg_ana_cnt = acnt;
		reg_db      = db;
		n_settings++;
	endtask

	// Mostly steady plant values with occasional changes, so the sequence
	// number climbs and the interval gets to double up to the time-to-live.
	task automatic queue_random_ticks(int count);
		int                r;
		logic [TIME_W-1:0] step;
		logic [TIME_W-1:0] min_iv;
		logic [TIME_W-1:0] ttl_ns;
		logic [DIG_W-1:0]  bits;
		analog_vec_t       av;
		logic [ANA_W-1:0]  db32;
		logic [ANA_W-1:0]  mag;
		bit                changed;
		logic [TIME_W-1:0] now;

		min_iv = TIME_W'(reg_min_iv);
		ttl_ns = TIME_W'(reg_ttl_ms) * 64'd1000000;
		for (int n = 0; n < count; n++) begin
			now = gen_now;
			r = $urandom_range(99);
			if (r < 25) step = TIME_W'($urandom_range(reg_min_iv, 0));
			else if (r < 50) step = min_iv << $urandom_range(8);
			else if (r < 60) step = (min_iv << $urandom_range(8)) - 1;
			else if (r < 72) step = ttl_ns + TIME_W'($urandom_range(2)) - 1;
			else if (r < 82) step = TIME_W'($urandom_range(1));
			else if (r < 90) step = {$urandom, $urandom};
			else if (r < 95) step = -TIME_W'($urandom_range(1000, 1));
			else step = '0;
			if (r >= 95) now = {TIME_W{1'b1}} - TIME_W'($urandom_range(3));
			else now = now + step;

			bits    = gen_bits;
			av      = gen_av;
			changed = $urandom_range(99) < 25;
			if (changed) begin
				r = $urandom_range(99);
				if (r < 50) bits = bits ^ (DIG_W'(1) << $urandom_range(DIG_W - 1));
				else if (r < 80) bits = bits ^ DIG_W'($urandom);
				else if (r < 95) bits = DIG_W'($urandom);
			end
			for (int j = 0; j < ANA_CH; j++) begin
				db32 = {1'b0, reg_db[j]};
				mag  = (db32 == 0) ? '0 : ANA_W'($urandom_range(db32 - 1, 0));
				r    = $urandom_range(99);
				if (!changed || r < 30) begin
					// drift under the deadband, or hold
					if ($urandom_range(99) < 30)
						av[j] = $urandom_range(1) ? av[j] + mag : av[j] - mag;
				end else if (r < 70) begin
					// right on the deadband edge
					mag   = db32 + ANA_W'($urandom_range(2)) - 1;
					av[j] = $urandom_range(1) ? av[j] + mag : av[j] - mag;
				end else if (r < 88) begin
					av[j] = $urandom;
				end else begin
					// full-scale swing between the extremes
					av[j] = av[j][ANA_W-1] ? 32'h7FFF_FFFF : 32'h8000_0000;
				end
			end
			push_tick(now, bits, av[0], av[1], av[2], av[3]);
		end
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		deadband_vec_t        db;
		logic [MIN_W-1:0]     mn;
		logic [TTL_MS_W-1:0]  tl;
		logic [DIG_CNT_W-1:0] dc;
		logic [ANA_CNT_W-1:0] ac;
		int                   r;

		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = CFG_MIN_INTERVAL;
		cfg_wdata            = '0;
		tick_ch.valid        = 1'b0;
		tick_ch.now_ns       = '0;
		tick_ch.digital_bits = '0;
		tick_ch.analog_v0    = '0;
		tick_ch.analog_v1    = '0;
		tick_ch.analog_v2    = '0;
		tick_ch.analog_v3    = '0;
		frame_ch.ready       = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults publish no channel: never a send, state stays put
		push_tick(64'd0, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF);
		push_tick(64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'd0, 32'd0);
		wait_quiet();

		// Counts past the channels present, shortest interval, zero
		// time-to-live, zero and full-scale deadbands
		db[0] = '0;
		db[1] = 31'h7FFF_FFFF;
		db[2] = 31'd1;
		db[3] = 31'd100;
		program_regs(32'd1, 16'd0, 5'd31, 3'd7, db);
		push_tick(64'd0, 16'h0000, 32'd0, 32'd0, 32'd0, 32'd0);
		push_tick(64'd5, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF);
		push_tick(64'd5, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF);
		push_tick(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'd2, 32'h0000_0063);
		push_tick(64'd3, 16'hAAAA, 32'h8000_0000, 32'h7FFF_FFFF, 32'd2, 32'h0000_0063);
		push_tick(64'd2, 16'h5555, 32'h8000_0000, 32'h7FFF_FFFF, 32'd2, 32'h0000_0063);
		push_tick(64'd2, 16'h5555, 32'h8000_0000, 32'h7FFF_FFFF, 32'd2, 32'h0000_0063);
		push_tick(64'd9, 16'h5555, 32'h8000_0000, 32'h7FFF_FFFF, 32'd2, 32'h0000_0063);
		wait_quiet();

		// Longest interval and time-to-live; sends only on the exact boundary
		db = {4{31'h7FFF_FFFF}};
		program_regs(32'hFFFF_FFFF, 16'hFFFF, 5'd16, 3'd4, db);
		push_tick(64'd0, 16'h5555, 32'd0, 32'd0, 32'd0, 32'd0);
		push_tick(64'hFFFF_FFFE, 16'h5555, 32'h7FFF_FFFE, 32'd0, 32'd0, 32'd0);
		push_tick(64'hFFFF_FFFF, 16'h5555, 32'h7FFF_FFFE, 32'd0, 32'd0, 32'd0);
		push_tick(64'h1_FFFF_FFFD, 16'h5555, 32'h7FFF_FFFE, 32'd0, 32'd0, 32'd0);
		push_tick(64'h2_FFFF_FFFD, 16'h5555, 32'h7FFF_FFFE, 32'd0, 32'd0, 32'd0);
		wait_quiet();

		// One digital channel only; once the interval falls to a zero
		// time-to-live a frame goes out every tick
		db = '0;
		program_regs(32'd1000, 16'd0, 5'd1, 3'd0, db);
		push_tick(64'd0, 16'hFFFE, 32'd0, 32'd0, 32'd0, 32'd0);
		push_tick(64'd1000, 16'h0000, 32'd7, 32'd7, 32'd7, 32'd7);
		push_tick(64'd1000, 16'h0000, 32'd7, 32'd7, 32'd7, 32'd7);
		push_tick(64'd1000, 16'h0001, 32'd7, 32'd7, 32'd7, 32'd7);
		push_tick(64'd1500, 16'h0001, 32'd7, 32'd7, 32'd7, 32'd7);
		push_tick(64'd2000, 16'h0001, 32'd7, 32'd7, 32'd7, 32'd7);
		wait_quiet();

		// Random part: one register setting per phase, extremes among them
		for (int p = 0; p < 9; p++) begin
			r = $urandom_range(99);
			if (r < 30) mn = $urandom_range(1000, 1);
			else if (r < 60) mn = $urandom_range(5000000, 1000);
			else mn = $urandom;
			if (mn == 0) mn = 32'd1;
			r = $urandom_range(99);
			if (r < 20) tl = '0;
			else if (r < 40) tl = TTL_MS_W'($urandom_range(3));
			else if (r < 70) tl = TTL_MS_W'($urandom_range(2000));
			else tl = TTL_MS_W'($urandom_range(16'hFFFF));
			dc = ($urandom_range(99) < 10) ? DIG_CNT_W'($urandom_range(31, 17))
				: DIG_CNT_W'($urandom_range(DIG_CH));
			ac = ($urandom_range(99) < 10) ? ANA_CNT_W'($urandom_range(7, 5))
				: ANA_CNT_W'($urandom_range(ANA_CH));
			for (int j = 0; j < ANA_CH; j++) begin
				r = $urandom_range(99);
				if (r < 20) db[j] = '0;
				else if (r < 70) db[j] = DB_W'($urandom_range(262144));
				else if (r < 85) db[j] = DB_W'($urandom);
				else db[j] = 31'h7FFF_FFFF;
			end
			case (p)
				0: begin
					mn = MIN_INTERVAL_RST;
					tl = TTL_MS_RST;
					dc = 5'd16;
					ac = 3'd4;
				end
				1: begin
					mn = 32'hFFFF_FFFF;
					tl = 16'hFFFF;
				end
				2: begin
					mn = 32'd1;
					tl = 16'd0;
				end
				3: begin
					dc = '0;
					ac = '0;
				end
				default: ;
			endcase
			program_regs(mn, tl, dc, ac, db);
			queue_random_ticks(55);
			wait_quiet();
		end

		if (frames_due.size() != 0) begin
			$error("%0d predicted frames never arrived", frames_due.size());
			mismatches++;
		end
		$display("%0d ticks checked over %0d register settings, %0d of them sending a frame",
			n_checked, n_settings, n_sends);
		$display("flow regimes cycled every %0d ticks, %0d long receiver hold-offs",
			FLOW_SPAN, n_holds);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

[goose_publish_scheduler.f]
+incdir+hdl
hdl/gps_pkg.sv
hdl/gps_in_if.sv
hdl/gps_out_if.sv
hdl/gps_change.sv
hdl/goose_publish_scheduler.sv
hdl/gps_checker.sv
sim/goose_publish_scheduler_test.sv
